// File: sv/tip_pkg.sv
// tagged interval profiler: shared types, codes and default constants
// used by the controller, the datapath and the top level
`timescale 1ns / 1ps

package tip_pkg;

  // default sizes
  localparam int ENTRIES_DEF   = 64;
  localparam int TIME_BITS_DEF = 48;
  localparam int TAG_BITS_DEF  = 32;

  // port field widths
  localparam int CMD_W    = 2;
  localparam int KEY_W    = 32;
  localparam int TS_W     = 48;
  localparam int IDX_W    = 6;
  localparam int ST_W     = 2;
  localparam int SLOT_W   = 6;
  localparam int IVL_W    = 48;
  localparam int TOT_W    = 64;
  localparam int CNT_W    = 32;
  localparam int SUM_W    = 49;
  localparam int USED_W   = 7;
  localparam int DIV_W    = 32;

  localparam logic [DIV_W-1:0] TPM_RESET = 32'd10;

  typedef enum logic [CMD_W-1:0] {
    CMD_BEGIN = 2'd0,
    CMD_END   = 2'd1,
    CMD_RESET = 2'd2,
    CMD_READ  = 2'd3
  } cmd_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_NOTFOUND = 2'd2,
    ST_NEGATIVE = 2'd3
  } status_t;

  // which fields a response carries
  typedef enum logic [1:0] {
    RK_PLAIN = 2'd0,
    RK_SLOT  = 2'd1,
    RK_END   = 2'd2,
    RK_READ  = 2'd3
  } rsp_kind_t;

  // controller to datapath commands
  typedef struct packed {
    logic      ld_in;
    logic      addr_inc;
    logic      wr_start;
    logic      alloc;
    logic      div_go;
    logic      rec_wr;
    logic      mm_ld;
    logic      tbl_clr;
    logic      rsp;
    status_t   rsp_status;
    rsp_kind_t rsp_kind;
  } tip_ctl_t;

  // datapath to controller status
  typedef struct packed {
    logic full;
    logic addr_end;
    logic tag_hit;
    logic div_done;
    logic neg_big;
    logic idx_ok;
  } tip_sts_t;

endpackage

// File: sv/tip_div.sv
// tagged interval profiler: restoring divider, one quotient bit per cycle
// depends on tip_pkg
`timescale 1ns / 1ps

module tip_div import tip_pkg::*; #(
  parameter int W = TIME_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             go,
  input  logic [W-1:0]     dividend,
  input  logic [DIV_W-1:0] divisor,
  output logic             done,
  output logic [W-1:0]     quotient
);

  localparam int CW = $clog2(W + 1);

  logic [DIV_W-1:0] rem;
  logic [DIV_W-1:0] dv;
  logic [W-1:0]     quo;
  logic [CW-1:0]    cnt;
  logic             run;
  logic [DIV_W:0]   trial;
  logic [DIV_W:0]   diff;
  logic             fits;

  // trial subtract of the shifted remainder
  assign trial = {rem, quo[W-1]};
  assign diff  = trial - {1'b0, dv};
  assign fits  = trial >= {1'b0, dv};

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (go) begin
        run <= 1'b1;
        cnt <= CW'(W);
      end else if (run) begin
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // remainder and quotient shift
  always_ff @(posedge clk) begin
    if (go) begin
      rem <= '0;
      quo <= dividend;
      dv  <= (divisor == '0) ? DIV_W'(1) : divisor;
    end else if (run) begin
      rem <= fits ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
      quo <= {quo[W-2:0], fits};
    end
  end

  assign quotient = quo;

endmodule

// File: sv/tip_datapath.sv
// tagged interval profiler: entry memories, scan pointer, divider,
// record update, read trimming and result registers; depends on tip_pkg, tip_div
`timescale 1ns / 1ps

module tip_datapath import tip_pkg::*; #(
  parameter int ENTRIES   = ENTRIES_DEF,
  parameter int TIME_BITS = TIME_BITS_DEF,
  parameter int TAG_BITS  = TAG_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic [CMD_W-1:0]   command,
  input  logic [KEY_W-1:0]   tag_key,
  input  logic [TS_W-1:0]    timestamp,
  input  logic [IDX_W-1:0]   entry_index,
  input  logic               tpm_write,
  input  logic [DIV_W-1:0]   ticks_per_microsecond,
  input  tip_ctl_t           ctl,
  output tip_sts_t           sts,
  output logic               done,
  output logic [ST_W-1:0]    status,
  output logic [SLOT_W-1:0]  slot,
  output logic [IVL_W-1:0]   interval_us,
  output logic [TOT_W-1:0]   trimmed_total,
  output logic [CNT_W-1:0]   trimmed_count,
  output logic [SUM_W-1:0]   min_sum,
  output logic [SUM_W-1:0]   max_sum,
  output logic [USED_W-1:0]  entries_used
);

  localparam int UW = $clog2(ENTRIES + 1);
  localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int TB = TIME_BITS;

  // configuration register
  logic [DIV_W-1:0] tpm;
  always_ff @(posedge clk) begin
    if (rst) begin
      tpm <= TPM_RESET;
    end else if (tpm_write) begin
      tpm <= ticks_per_microsecond;
    end
  end

  // latched item
  logic [TAG_BITS-1:0] key_q;
  logic [TB-1:0]       ts_q;
  logic [IDX_W-1:0]    idx_q;
  logic [UW-1:0]       addr;
  logic [UW-1:0]       used;
  logic [UW-1:0]       used_next;
  logic [IW-1:0]       aidx;

  assign aidx = addr[IW-1:0];

  always_ff @(posedge clk) begin
    if (ctl.ld_in) begin
      key_q <= TAG_BITS'(tag_key);
      ts_q  <= TB'(timestamp);
      idx_q <= entry_index;
    end
  end

  // scan pointer, also the entry address
  always_ff @(posedge clk) begin
    if (ctl.ld_in) begin
      addr <= (cmd_t'(command) == CMD_READ) ? UW'(entry_index) : '0;
    end else if (ctl.addr_inc) begin
      addr <= addr + 1'b1;
    end
  end

  // allocated entry count
  always_comb begin
    used_next = used;
    if (ctl.tbl_clr) begin
      used_next = '0;
    end else if (ctl.alloc) begin
      used_next = used + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      used <= '0;
    end else begin
      used <= used_next;
    end
  end

  // entry memories
  logic [TAG_BITS-1:0] tag_mem [ENTRIES];
  logic [TB-1:0]       start_mem [ENTRIES];
  logic [TOT_W-1:0]    tot_mem [ENTRIES];
  logic [CNT_W-1:0]    cnt_mem [ENTRIES];
  logic [TB-1:0]       lf_mem [ENTRIES];
  logic [TB-1:0]       ls_mem [ENTRIES];
  logic [TB-1:0]       hf_mem [ENTRIES];
  logic [TB-1:0]       hs_mem [ENTRIES];

  logic [TAG_BITS-1:0] tag_rd;
  logic [TB-1:0]       start_rd;
  logic [TOT_W-1:0]    tot_rd;
  logic [CNT_W-1:0]    cnt_rd;
  logic [TB-1:0]       lf_rd, ls_rd, hf_rd, hs_rd;

  logic [TOT_W-1:0]    tot_new;
  logic [CNT_W-1:0]    cnt_new;
  logic [TB-1:0]       lf_new, ls_new, hf_new, hs_new;

  always_ff @(posedge clk) begin
    if (ctl.alloc) begin
      tag_mem[aidx] <= key_q;
    end
    tag_rd <= tag_mem[aidx];
  end

  always_ff @(posedge clk) begin
    if (ctl.alloc || ctl.wr_start) begin
      start_mem[aidx] <= ts_q;
    end
    start_rd <= start_mem[aidx];
  end

  always_ff @(posedge clk) begin
    if (ctl.alloc) begin
      tot_mem[aidx] <= '0;
      cnt_mem[aidx] <= '0;
      lf_mem[aidx]  <= '0;
      ls_mem[aidx]  <= '0;
      hf_mem[aidx]  <= '0;
      hs_mem[aidx]  <= '0;
    end else if (ctl.rec_wr) begin
      tot_mem[aidx] <= tot_new;
      cnt_mem[aidx] <= cnt_new;
      lf_mem[aidx]  <= lf_new;
      ls_mem[aidx]  <= ls_new;
      hf_mem[aidx]  <= hf_new;
      hs_mem[aidx]  <= hs_new;
    end
    tot_rd <= tot_mem[aidx];
    cnt_rd <= cnt_mem[aidx];
    lf_rd  <= lf_mem[aidx];
    ls_rd  <= ls_mem[aidx];
    hf_rd  <= hf_mem[aidx];
    hs_rd  <= hs_mem[aidx];
  end

  // elapsed ticks magnitude and direction
  logic          neg;
  logic          neg_q;
  logic [TB-1:0] mag;
  logic [TB-1:0] q;
  logic          div_done;

  assign neg = ts_q < start_rd;
  assign mag = neg ? (start_rd - ts_q) : (ts_q - start_rd);

  always_ff @(posedge clk) begin
    if (ctl.div_go) begin
      neg_q <= neg;
    end
  end

  tip_div #(.W(TB)) u_div (
    .clk      (clk),
    .rst      (rst),
    .go       (ctl.div_go),
    .dividend (mag),
    .divisor  (tpm),
    .done     (div_done),
    .quotient (q)
  );

  // record update with the new interval
  logic [TOT_W:0] tot_sum;
  assign tot_sum = {1'b0, tot_rd} + {1'b0, TOT_W'(q)};

  always_comb begin
    tot_new = tot_sum[TOT_W] ? '1 : tot_sum[TOT_W-1:0];
    cnt_new = (cnt_rd != '1) ? cnt_rd + 1'b1 : cnt_rd;
    lf_new  = lf_rd;
    ls_new  = ls_rd;
    hf_new  = hf_rd;
    hs_new  = hs_rd;
    if ((q < lf_rd && q != '0) || lf_rd == '0) begin
      lf_new = q;
    end else if ((q < ls_rd && q != '0) || ls_rd == '0) begin
      ls_new = q;
    end else if (q > hf_rd) begin
      hf_new = q;
    end else if (q > hs_rd) begin
      hs_new = q;
    end
  end

  // extreme sums for read
  logic [TB:0]      mins_r, maxs_r;
  logic [TOT_W-1:0] ext;
  logic [TOT_W-1:0] trim_tot;
  logic [CNT_W-1:0] trim_cnt;

  always_ff @(posedge clk) begin
    if (ctl.mm_ld) begin
      mins_r <= {1'b0, lf_rd} + {1'b0, ls_rd};
      maxs_r <= {1'b0, hf_rd} + {1'b0, hs_rd};
    end
  end

  assign ext = TOT_W'(mins_r) + TOT_W'(maxs_r);

  always_comb begin
    trim_tot = tot_rd;
    trim_cnt = cnt_rd;
    if (cnt_rd > CNT_W'(4)) begin
      trim_tot = (tot_rd > ext) ? tot_rd - ext : '0;
      trim_cnt = cnt_rd - CNT_W'(4);
    end
  end

  // status to controller
  assign sts.full     = used >= UW'(ENTRIES);
  assign sts.addr_end = addr >= used;
  assign sts.tag_hit  = tag_rd == key_q;
  assign sts.div_done = div_done;
  assign sts.neg_big  = neg_q && (q != '0);
  assign sts.idx_ok   = 32'(idx_q) < 32'(used);

  // result registers
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= ctl.rsp;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.rsp) begin
      status        <= ctl.rsp_status;
      entries_used  <= USED_W'(used_next);
      slot          <= '0;
      interval_us   <= '0;
      trimmed_total <= '0;
      trimmed_count <= '0;
      min_sum       <= '0;
      max_sum       <= '0;
      case (ctl.rsp_kind)
        RK_SLOT: begin
          slot <= SLOT_W'(addr);
        end
        RK_END: begin
          slot        <= SLOT_W'(addr);
          interval_us <= IVL_W'(q);
        end
        RK_READ: begin
          slot          <= SLOT_W'(addr);
          trimmed_total <= trim_tot;
          trimmed_count <= trim_cnt;
          min_sum       <= SUM_W'(mins_r);
          max_sum       <= SUM_W'(maxs_r);
        end
        default: begin
        end
      endcase
    end
  end

endmodule

// File: sv/tip_ctrl.sv
// tagged interval profiler: command sequencer
// depends on tip_pkg
`timescale 1ns / 1ps

module tip_ctrl import tip_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [CMD_W-1:0] command,
  input  tip_sts_t         sts,
  output tip_ctl_t         ctl,
  output logic             busy
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHK,
    S_CMP,
    S_DIV,
    S_REC,
    S_RCHK,
    S_RWAIT,
    S_RTRIM
  } state_t;

  state_t state, state_next;
  cmd_t   cmd_q;

  // state and latched command
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cmd_q <= CMD_BEGIN;
    end else begin
      state <= state_next;
      if (state == S_IDLE && start) begin
        cmd_q <= cmd_t'(command);
      end
    end
  end

  assign busy = state != S_IDLE;

  // next state and datapath commands
  always_comb begin
    state_next     = state;
    ctl            = '0;
    ctl.rsp_status = ST_OK;
    ctl.rsp_kind   = RK_PLAIN;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          ctl.ld_in = 1'b1;
          unique case (cmd_t'(command))
            CMD_BEGIN: begin
              if (sts.full) begin
                ctl.rsp        = 1'b1;
                ctl.rsp_status = ST_FULL;
              end else begin
                state_next = S_CHK;
              end
            end
            CMD_END: begin
              state_next = S_CHK;
            end
            CMD_RESET: begin
              ctl.tbl_clr = 1'b1;
              ctl.rsp     = 1'b1;
            end
            CMD_READ: begin
              state_next = S_RCHK;
            end
            default: begin
            end
          endcase
        end
      end
      S_CHK: begin
        if (sts.addr_end) begin
          ctl.rsp    = 1'b1;
          state_next = S_IDLE;
          if (cmd_q == CMD_BEGIN) begin
            ctl.alloc    = 1'b1;
            ctl.rsp_kind = RK_SLOT;
          end else begin
            ctl.rsp_status = ST_NOTFOUND;
          end
        end else begin
          state_next = S_CMP;
        end
      end
      S_CMP: begin
        if (sts.tag_hit) begin
          if (cmd_q == CMD_BEGIN) begin
            ctl.wr_start = 1'b1;
            ctl.rsp      = 1'b1;
            ctl.rsp_kind = RK_SLOT;
            state_next   = S_IDLE;
          end else begin
            ctl.div_go = 1'b1;
            state_next = S_DIV;
          end
        end else begin
          ctl.addr_inc = 1'b1;
          state_next   = S_CHK;
        end
      end
      S_DIV: begin
        if (sts.div_done) begin
          state_next = S_REC;
        end
      end
      S_REC: begin
        ctl.rsp    = 1'b1;
        state_next = S_IDLE;
        if (sts.neg_big) begin
          ctl.rsp_status = ST_NEGATIVE;
          ctl.rsp_kind   = RK_SLOT;
        end else begin
          ctl.rec_wr   = 1'b1;
          ctl.rsp_kind = RK_END;
        end
      end
      S_RCHK: begin
        if (sts.idx_ok) begin
          state_next = S_RWAIT;
        end else begin
          ctl.rsp        = 1'b1;
          ctl.rsp_status = ST_NOTFOUND;
          state_next     = S_IDLE;
        end
      end
      S_RWAIT: begin
        ctl.mm_ld  = 1'b1;
        state_next = S_RTRIM;
      end
      S_RTRIM: begin
        ctl.rsp      = 1'b1;
        ctl.rsp_kind = RK_READ;
        state_next   = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// File: sv/tagged_interval_profiler_core.sv
// tagged interval profiler: top level joining sequencer and datapath
// depends on tip_pkg, tip_ctrl, tip_datapath
//
// channel   direction  transfer
// command   in         start high while busy low: command, tag_key, timestamp, entry_index
// result    out        done high for one cycle: status .. entries_used
// config    in         tpm_write high: ticks_per_microsecond
//
// begin and end scan the tag table, comparing one entry after another;
// an end that hits an entry then runs the bit-serial divide and updates
// the record. read checks the index, loads the extreme sums and trims;
// reset table and a begin on a full table answer straight from idle.
// busy is low while the result is up, so a new command may start then;
// results are never held off. rst clears the table and sets the divisor to 10.
`timescale 1ns / 1ps

module tagged_interval_profiler_core import tip_pkg::*; #(
  parameter int ENTRIES   = ENTRIES_DEF,
  parameter int TIME_BITS = TIME_BITS_DEF,
  parameter int TAG_BITS  = TAG_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  logic [CMD_W-1:0]  command,
  input  logic [KEY_W-1:0]  tag_key,
  input  logic [TS_W-1:0]   timestamp,
  input  logic [IDX_W-1:0]  entry_index,
  input  logic              tpm_write,
  input  logic [DIV_W-1:0]  ticks_per_microsecond,
  output logic              done,
  output logic [ST_W-1:0]   status,
  output logic [SLOT_W-1:0] slot,
  output logic [IVL_W-1:0]  interval_us,
  output logic [TOT_W-1:0]  trimmed_total,
  output logic [CNT_W-1:0]  trimmed_count,
  output logic [SUM_W-1:0]  min_sum,
  output logic [SUM_W-1:0]  max_sum,
  output logic [USED_W-1:0] entries_used
);

  tip_ctl_t ctl;
  tip_sts_t sts;

  tip_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .command (command),
    .sts     (sts),
    .ctl     (ctl),
    .busy    (busy)
  );

  tip_datapath #(
    .ENTRIES   (ENTRIES),
    .TIME_BITS (TIME_BITS),
    .TAG_BITS  (TAG_BITS)
  ) u_dp (
    .clk                   (clk),
    .rst                   (rst),
    .command               (command),
    .tag_key               (tag_key),
    .timestamp             (timestamp),
    .entry_index           (entry_index),
    .tpm_write             (tpm_write),
    .ticks_per_microsecond (ticks_per_microsecond),
    .ctl                   (ctl),
    .sts                   (sts),
    .done                  (done),
    .status                (status),
    .slot                  (slot),
    .interval_us           (interval_us),
    .trimmed_total         (trimmed_total),
    .trimmed_count         (trimmed_count),
    .min_sum               (min_sum),
    .max_sum               (max_sum),
    .entries_used          (entries_used)
  );

endmodule
